@@ rtl/timed_event_sorted_queue_defines.svh @@
// Assertion macros shared by the event queue modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef TIMED_EVENT_SORTED_QUEUE_DEFINES_SVH
`define TIMED_EVENT_SORTED_QUEUE_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define TESQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define TESQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TESQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/tesq_pkg.sv @@
// Shared types and field widths of the timed event queue.
// No dependencies; every module and interface file imports this package.
package tesq_pkg;

  localparam int TIME_W    = 64;
  localparam int INC_W     = 32;
  localparam int TAG_W     = 3;
  localparam int CNT_OUT_W = 5;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_e_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic commit;
  } dp_cmd_t;

endpackage

@@ rtl/tesq_ifs.sv @@
// Valid/ready channel interfaces for request and result items.
// Depends on tesq_pkg for the field widths.
interface tesq_in_if import tesq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [TIME_W-1:0] base_time;
  logic [INC_W-1:0]  time_increment;
  logic [TAG_W-1:0]  int_line;
  logic [TAG_W-1:0]  dev_number;

  modport source (output valid, command, base_time, time_increment, int_line, dev_number,
                  input ready);
  modport sink   (input valid, command, base_time, time_increment, int_line, dev_number,
                  output ready);
endinterface

interface tesq_out_if import tesq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 queue_empty;
  logic [TIME_W-1:0]    head_time;
  logic [TAG_W-1:0]     head_int_line;
  logic [TAG_W-1:0]     head_dev_number;
  logic [TIME_W-1:0]    inserted_time;
  logic                 overflow;
  logic [CNT_OUT_W-1:0] entry_count;

  modport source (output valid, queue_empty, head_time, head_int_line, head_dev_number,
                  inserted_time, overflow, entry_count, input ready);
  modport sink   (input valid, queue_empty, head_time, head_int_line, head_dev_number,
                  inserted_time, overflow, entry_count, output ready);
endinterface

@@ rtl/timed_event_sorted_queue.sv @@
// Channel    | Dir | Handshake          | Payload
// in_ch      | in  | valid/ready        | command, base_time, time_increment, int_line, dev_number
// out_ch     | out | valid/ready        | queue_empty, head_time, head_int_line, head_dev_number,
//            |     |                    | inserted_time, overflow, entry_count
// An item is captured in S_IDLE, where the increment is added, then committed in S_EXEC,
// which compares the event time against every slot at once and shifts the slot row.
// One result per item, held in an output register; the next request is taken while it waits.
// A stalled output holds the commit cycle until the result register frees.
// Reset clears the count, state and result valid; slot contents stay undefined and need no clearing pass.
module timed_event_sorted_queue import tesq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic        clk,
  input logic        rst_n,
  tesq_in_if.sink    in_ch,
  tesq_out_if.source out_ch
);

  dp_cmd_t dp_cmd;

  tesq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (dp_cmd)
  );

  tesq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (dp_cmd),
    .in_command          (in_ch.command),
    .in_base_time        (in_ch.base_time),
    .in_time_increment   (in_ch.time_increment),
    .in_int_line         (in_ch.int_line),
    .in_dev_number       (in_ch.dev_number),
    .out_queue_empty     (out_ch.queue_empty),
    .out_head_time       (out_ch.head_time),
    .out_head_int_line   (out_ch.head_int_line),
    .out_head_dev_number (out_ch.head_dev_number),
    .out_inserted_time   (out_ch.inserted_time),
    .out_overflow        (out_ch.overflow),
    .out_entry_count     (out_ch.entry_count)
  );

endmodule

@@ rtl/tesq_ctrl.sv @@
// Controller of the event queue: request capture, commit and result valid.
// Depends on tesq_pkg and the assertion macros header.
`include "timed_event_sorted_queue_defines.svh"

module tesq_ctrl import tesq_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready    = (state_r == S_IDLE);
  assign out_free    = !out_valid_r || out_ready;
  assign cmd.capture = in_valid && in_ready;
  // Commit only when the result register can take the new result.
  assign cmd.commit  = (state_r == S_EXEC) && out_free;
  assign out_valid   = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd.capture) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `TESQ_ASSERT_NXT(a_commit_shows, cmd.commit, out_valid_r, "commit did not raise result valid")
  `TESQ_ASSERT_ALWAYS(a_no_overlap, !(cmd.capture && cmd.commit), "capture and commit together")
  `TESQ_ASSERT_NXT(a_result_held, out_valid_r && !out_ready, out_valid_r,
                   "stalled result was dropped")

endmodule

@@ rtl/tesq_datapath.sv @@
// Datapath of the event queue: request registers, sorted slot row, result registers.
// Depends on tesq_pkg and the assertion macros header.
`include "timed_event_sorted_queue_defines.svh"

module tesq_datapath import tesq_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  input  logic                 in_command,
  input  logic [TIME_W-1:0]    in_base_time,
  input  logic [INC_W-1:0]     in_time_increment,
  input  logic [TAG_W-1:0]     in_int_line,
  input  logic [TAG_W-1:0]     in_dev_number,
  output logic                 out_queue_empty,
  output logic [TIME_W-1:0]    out_head_time,
  output logic [TAG_W-1:0]     out_head_int_line,
  output logic [TAG_W-1:0]     out_head_dev_number,
  output logic [TIME_W-1:0]    out_inserted_time,
  output logic                 out_overflow,
  output logic [CNT_OUT_W-1:0] out_entry_count
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Captured request
  cmd_e_t            req_cmd_r;
  logic [TIME_W-1:0] req_time_r;
  logic [TAG_W-1:0]  req_line_r;
  logic [TAG_W-1:0]  req_dev_r;

  // Slot row, slot 0 is the head
  logic [TIME_W-1:0] slot_time_r [QUEUE_DEPTH];
  logic [TAG_W-1:0]  slot_line_r [QUEUE_DEPTH];
  logic [TAG_W-1:0]  slot_dev_r  [QUEUE_DEPTH];
  logic [TIME_W-1:0] slot_time_nxt [QUEUE_DEPTH];
  logic [TAG_W-1:0]  slot_line_nxt [QUEUE_DEPTH];
  logic [TAG_W-1:0]  slot_dev_nxt  [QUEUE_DEPTH];
  logic [CNT_W-1:0]  count_r, count_nxt;

  // Result registers
  logic                 res_empty_r;
  logic [TIME_W-1:0]    res_head_time_r;
  logic [TAG_W-1:0]     res_head_line_r;
  logic [TAG_W-1:0]     res_head_dev_r;
  logic [TIME_W-1:0]    res_ins_time_r;
  logic                 res_ovf_r;
  logic [CNT_OUT_W-1:0] res_count_r;

  logic                   full, empty, head_first, do_insert, do_remove;
  logic [QUEUE_DEPTH-1:0] at_or_after;  // insert position is at or below this slot
  logic [QUEUE_DEPTH-1:0] take_new;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty      = (count_r == '0);
  // Equal to the head time goes in front of the head.
  assign head_first = empty || (req_time_r <= slot_time_r[0]);
  assign do_insert  = (req_cmd_r == CMD_INSERT) && !full;
  assign do_remove  = (req_cmd_r == CMD_REMOVE) && !empty;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
    logic [TIME_W-1:0] up_time, dn_time;
    logic [TAG_W-1:0]  up_line, dn_line, up_dev, dn_dev;

    if (i == 0) begin : g_head
      assign at_or_after[i] = head_first;
      assign take_new[i]    = at_or_after[i];
      assign up_time        = req_time_r;
      assign up_line        = req_line_r;
      assign up_dev         = req_dev_r;
    end else begin : g_body
      // Sorted row: later slots past the first later time also sit after the insert.
      assign at_or_after[i] = head_first || (slot_time_r[i] > req_time_r) ||
                              (CNT_W'(i) >= count_r);
      assign take_new[i]    = at_or_after[i] && !at_or_after[i-1];
      assign up_time        = slot_time_r[i-1];
      assign up_line        = slot_line_r[i-1];
      assign up_dev         = slot_dev_r[i-1];
    end

    if (i < QUEUE_DEPTH - 1) begin : g_dn
      assign dn_time = slot_time_r[i+1];
      assign dn_line = slot_line_r[i+1];
      assign dn_dev  = slot_dev_r[i+1];
    end else begin : g_tail
      assign dn_time = slot_time_r[i];
      assign dn_line = slot_line_r[i];
      assign dn_dev  = slot_dev_r[i];
    end

    assign slot_time_nxt[i] =
      (do_insert && take_new[i])    ? req_time_r :
      (do_insert && at_or_after[i]) ? up_time    :
      do_remove                     ? dn_time    : slot_time_r[i];
    assign slot_line_nxt[i] =
      (do_insert && take_new[i])    ? req_line_r :
      (do_insert && at_or_after[i]) ? up_line    :
      do_remove                     ? dn_line    : slot_line_r[i];
    assign slot_dev_nxt[i] =
      (do_insert && take_new[i])    ? req_dev_r :
      (do_insert && at_or_after[i]) ? up_dev    :
      do_remove                     ? dn_dev    : slot_dev_r[i];
  end

  always_comb begin
    if (do_insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_remove) begin
      count_nxt = count_r - CNT_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  // Form the event time while capturing the request.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_cmd_r  <= cmd_e_t'(in_command);
      req_time_r <= in_base_time + TIME_W'(in_time_increment);
      req_line_r <= in_int_line;
      req_dev_r  <= in_dev_number;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      slot_time_r <= slot_time_nxt;
      slot_line_r <= slot_line_nxt;
      slot_dev_r  <= slot_dev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_empty_r     <= (count_nxt == '0);
      res_head_time_r <= (count_nxt == '0) ? '0 : slot_time_nxt[0];
      res_head_line_r <= (count_nxt == '0) ? '0 : slot_line_nxt[0];
      res_head_dev_r  <= (count_nxt == '0) ? '0 : slot_dev_nxt[0];
      res_ins_time_r  <= do_insert ? req_time_r : '0;
      res_ovf_r       <= (req_cmd_r == CMD_INSERT) && full;
      res_count_r     <= CNT_OUT_W'(count_nxt);
    end
  end

  assign out_queue_empty     = res_empty_r;
  assign out_head_time       = res_head_time_r;
  assign out_head_int_line   = res_head_line_r;
  assign out_head_dev_number = res_head_dev_r;
  assign out_inserted_time   = res_ins_time_r;
  assign out_overflow        = res_ovf_r;
  assign out_entry_count     = res_count_r;

  `TESQ_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(QUEUE_DEPTH), "count above depth")
  `TESQ_ASSERT_NXT(a_insert_count, cmd.commit && do_insert,
                   count_r == $past(count_r) + CNT_W'(1), "insert did not grow count")
  `TESQ_ASSERT_NXT(a_remove_empty, cmd.commit && (req_cmd_r == CMD_REMOVE) && empty,
                   count_r == '0, "remove on empty queue changed count")
  `TESQ_ASSERT_IMP(a_head_order, count_r >= CNT_W'(2),
                   slot_time_r[0] <= slot_time_r[1], "head later than second slot")

endmodule

@@ verif/tb_timed_event_sorted_queue.sv @@
// Self-checking bench for timed_event_sorted_queue: directed table, then random requests.
// Checks field by field against a sorted-queue model, or table values for typed rows.
// Depends on tesq_pkg and on the tesq_in_if / tesq_out_if interfaces.
module tb_timed_event_sorted_queue;
  import tesq_pkg::*;

  localparam int QUEUE_DEPTH    = 16;
  localparam int RANDOM_ITEMS   = 400;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_PRINTED    = 100;

  typedef struct packed {
    cmd_e_t            command;
    logic [TIME_W-1:0] base_time;
    logic [INC_W-1:0]  time_increment;
    logic [TAG_W-1:0]  int_line;
    logic [TAG_W-1:0]  dev_number;
  } request_t;

  typedef struct packed {
    logic                 queue_empty;
    logic [TIME_W-1:0]    head_time;
    logic [TAG_W-1:0]     head_int_line;
    logic [TAG_W-1:0]     head_dev_number;
    logic [TIME_W-1:0]    inserted_time;
    logic                 overflow;
    logic [CNT_OUT_W-1:0] entry_count;
  } result_t;

  typedef struct {
    request_t rq;
    bit       typed;
    result_t  want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n;

  tesq_in_if  in_ch ();
  tesq_out_if out_ch ();

  timed_event_sorted_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sorted event store of the predictor, slot 0 is the head.
  logic [TIME_W-1:0] sq_time [QUEUE_DEPTH];
  logic [TAG_W-1:0]  sq_line [QUEUE_DEPTH];
  logic [TAG_W-1:0]  sq_dev  [QUEUE_DEPTH];
  int                sq_count;

  result_t    pending_results [$];
  int         mismatch_count = 0;
  int         idle_cycles = 0;
  bit         no_idle;
  table_row_t directed_rows [25];

  function automatic result_t predict_queue_step(input request_t rq);
    result_t           r;
    logic [TIME_W-1:0] t;
    int                pos;
    int                i;
    r = '0;
    if (rq.command == CMD_INSERT) begin
      t = rq.base_time + TIME_W'(rq.time_increment);
      if (sq_count >= QUEUE_DEPTH) begin
        r.overflow = 1'b1;
      end else begin
        // A tie with the head goes in front; any other tie goes behind.
        if (sq_count == 0 || t <= sq_time[0]) begin
          pos = 0;
        end else begin
          pos = 1;
          while (pos < sq_count && sq_time[pos] <= t) pos++;
        end
        for (i = sq_count; i > pos; i--) begin
          sq_time[i] = sq_time[i-1];
          sq_line[i] = sq_line[i-1];
          sq_dev[i]  = sq_dev[i-1];
        end
        sq_time[pos] = t;
        sq_line[pos] = rq.int_line;
        sq_dev[pos]  = rq.dev_number;
        sq_count++;
        r.inserted_time = t;
      end
    end else if (sq_count != 0) begin
      for (i = 1; i < sq_count; i++) begin
        sq_time[i-1] = sq_time[i];
        sq_line[i-1] = sq_line[i];
        sq_dev[i-1]  = sq_dev[i];
      end
      sq_count--;
    end
    r.queue_empty = (sq_count == 0);
    if (sq_count != 0) begin
      r.head_time       = sq_time[0];
      r.head_int_line   = sq_line[0];
      r.head_dev_number = sq_dev[0];
    end
    r.entry_count = CNT_OUT_W'(sq_count);
    return r;
  endfunction

  function automatic table_row_t mk_row(input cmd_e_t cmd, input logic [TIME_W-1:0] base,
                                        input logic [INC_W-1:0] inc, input logic [2:0] line,
                                        input logic [2:0] dev, input bit typed,
                                        input result_t want);
    table_row_t row;
    row.rq    = '{command: cmd, base_time: base, time_increment: inc,
                  int_line: line, dev_number: dev};
    row.typed = typed;
    row.want  = want;
    return row;
  endfunction

  function automatic result_t res(input logic empty, input logic [TIME_W-1:0] ht,
                                  input logic [2:0] hl, input logic [2:0] hd,
                                  input logic [TIME_W-1:0] ins, input logic ovf,
                                  input logic [CNT_OUT_W-1:0] cnt);
    return '{queue_empty: empty, head_time: ht, head_int_line: hl, head_dev_number: hd,
             inserted_time: ins, overflow: ovf, entry_count: cnt};
  endfunction

  task automatic flag_mismatch(input string what, input logic [TIME_W-1:0] got,
                               input logic [TIME_W-1:0] want);
    if (mismatch_count < MAX_PRINTED)
      $display("ERROR: %s got 0x%0h expected 0x%0h", what, got, want);
    mismatch_count++;
  endtask

  // Drive one request, hold it until accepted, then queue its expected result.
  task automatic send_request(input request_t rq, input bit typed, input result_t want);
    int      gap;
    result_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.command        <= rq.command;
    in_ch.base_time      <= rq.base_time;
    in_ch.time_increment <= rq.time_increment;
    in_ch.int_line       <= rq.int_line;
    in_ch.dev_number     <= rq.dev_number;
    do @(posedge clk); while (!in_ch.ready);
    predicted = predict_queue_step(rq);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Result side: random stalls, compare every accepted result with the oldest expectation.
  initial begin
    int      stall;
    result_t want;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_ch.valid));
      if (pending_results.size() == 0) begin
        flag_mismatch("result with no request pending", out_ch.head_time, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.queue_empty !== want.queue_empty)
          flag_mismatch("queue_empty", out_ch.queue_empty, want.queue_empty);
        if (out_ch.head_time !== want.head_time)
          flag_mismatch("head_time", out_ch.head_time, want.head_time);
        if (out_ch.head_int_line !== want.head_int_line)
          flag_mismatch("head_int_line", out_ch.head_int_line, want.head_int_line);
        if (out_ch.head_dev_number !== want.head_dev_number)
          flag_mismatch("head_dev_number", out_ch.head_dev_number, want.head_dev_number);
        if (out_ch.inserted_time !== want.inserted_time)
          flag_mismatch("inserted_time", out_ch.inserted_time, want.inserted_time);
        if (out_ch.overflow !== want.overflow)
          flag_mismatch("overflow", out_ch.overflow, want.overflow);
        if (out_ch.entry_count !== want.entry_count)
          flag_mismatch("entry_count", out_ch.entry_count, want.entry_count);
      end
    end
  end

  // End the run when no request and no result moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    request_t rq;
    int       n;
    int       pct;
    int       sel;
    rst_n                = 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.command        <= CMD_INSERT;
    in_ch.base_time      <= '0;
    in_ch.time_increment <= '0;
    in_ch.int_line       <= '0;
    in_ch.dev_number     <= '0;
    sq_count       = 0;
    no_idle        = 1'b0;

    // Empty remove, wrapping insert, zero time, drain back to empty.
    directed_rows[0] = mk_row(CMD_REMOVE, '0, '0, 0, 0, 1, res(1, 0, 0, 0, 0, 0, 0));
    directed_rows[1] = mk_row(CMD_INSERT, '1, '1, 7, 7, 1,
                              res(0, 64'hFFFF_FFFE, 7, 7, 64'hFFFF_FFFE, 0, 1));
    directed_rows[2] = mk_row(CMD_INSERT, '0, '0, 0, 0, 1, res(0, 0, 0, 0, 0, 0, 2));
    directed_rows[3] = mk_row(CMD_REMOVE, '0, '0, 0, 0, 1,
                              res(0, 64'hFFFF_FFFE, 7, 7, 0, 0, 1));
    directed_rows[4] = mk_row(CMD_REMOVE, '0, '0, 0, 0, 1, res(1, 0, 0, 0, 0, 0, 0));
    // Ties: equal to head goes first, equal to a later slot goes after it.
    directed_rows[5] = mk_row(CMD_INSERT, 64'd100, 32'd0, 1, 1, 0, '0);
    directed_rows[6] = mk_row(CMD_INSERT, 64'd50, 32'd50, 2, 2, 0, '0);
    directed_rows[7] = mk_row(CMD_INSERT, 64'd100, 32'd5, 3, 3, 0, '0);
    directed_rows[8] = mk_row(CMD_INSERT, 64'd105, 32'd0, 4, 4, 0, '0);
    // Remove with busy payload fields, which must be ignored.
    directed_rows[9] = mk_row(CMD_REMOVE, '1, '1, 7, 7, 0, '0);
    // Fill to full, overflow, then free one slot.
    for (n = 10; n < 23; n++)
      directed_rows[n] = mk_row(CMD_INSERT, 64'((n * 37) % 200), 32'(n % 3), 3'(n), 3'(n + 3),
                                0, '0);
    directed_rows[23] = mk_row(CMD_INSERT, 64'd1, 32'd1, 5, 6, 0, '0);
    directed_rows[24] = mk_row(CMD_REMOVE, '0, '0, 0, 0, 0, '0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 120 && n < 180) || (n >= 300 && n < 340);
      case ((n / 50) % 4)
        0:       pct = 75;
        1:       pct = 25;
        2:       pct = 60;
        default: pct = 40;
      endcase
      // Hold off new requests until every result is back.
      if (n == 200) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      rq.command = ($urandom_range(0, 99) < pct) ? CMD_INSERT : CMD_REMOVE;
      sel = $urandom_range(0, 3);
      case (sel)
        0:       rq.base_time = 64'($urandom_range(0, 31));
        1:       rq.base_time = {$urandom, $urandom};
        2:       rq.base_time = {32'hFFFF_FFFF, $urandom};
        default: rq.base_time = 64'($urandom);
      endcase
      sel = $urandom_range(0, 2);
      case (sel)
        0:       rq.time_increment = 32'($urandom_range(0, 7));
        1:       rq.time_increment = $urandom;
        default: rq.time_increment = '1;
      endcase
      rq.int_line   = 3'($urandom);
      rq.dev_number = 3'($urandom);
      send_request(rq, 0, '0);
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
